FILE: sv/obo_pkg.sv
// ----------------------------------------------------------------------------
// obo_pkg: shared constants for the oriented box overlap test
// Field widths, tdata layout, stage counts and sine pipeline constants.
// ----------------------------------------------------------------------------
`default_nettype none

package obo_pkg;

  localparam int COORD_BITS     = 24;
  localparam int ANGLE_BITS     = 16;
  localparam int ANG_FIELD_BITS = 16;

  // field widths
  localparam int CW = COORD_BITS;        // signed centre
  localparam int XW = COORD_BITS - 1;    // unsigned half extent
  localparam int AW = ANG_FIELD_BITS;    // angle field

  // input tdata layout, first field in the lowest bits
  localparam int OFS_ACX = 0;
  localparam int OFS_ACY = OFS_ACX + CW;
  localparam int OFS_AHW = OFS_ACY + CW;
  localparam int OFS_AHH = OFS_AHW + XW;
  localparam int OFS_AAN = OFS_AHH + XW;
  localparam int OFS_BCX = OFS_AAN + AW;
  localparam int OFS_BCY = OFS_BCX + CW;
  localparam int OFS_BHW = OFS_BCY + CW;
  localparam int OFS_BHH = OFS_BHW + XW;
  localparam int OFS_BAN = OFS_BHH + XW;
  localparam int IN_FIELDS_W = OFS_BAN + AW;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 8;

  // sine/cosine
  localparam int            QB          = ANGLE_BITS - 2;   // bits of a quarter turn
  localparam logic [14:0]   Q15_ONE     = 15'd32767;
  localparam logic [30:0]   HALF_PI_Q30 = 31'd1686629713;
  localparam int            X_W         = 31;               // angle in radians, Q30
  localparam int            X2_W        = 32;               // x squared, Q30
  localparam int            TW          = 33;               // series term
  localparam int            SUM_W       = TW + 1;           // signed series sum
  localparam int            SIN_LAT     = 15;               // sine unit stages

  // whole pipeline: input stage, sine unit, four projection stages
  localparam int NST = SIN_LAT + 5;

  // projection widths
  localparam int DW  = CW + 1;           // centre difference
  localparam int PW  = DW + 16;          // offset times sine
  localparam int SW  = PW + 1;           // rotated offset
  localparam int EW  = XW + 15;          // extent times magnitude
  localparam int RW  = EW + 1;           // sum of two extent products
  localparam int LW  = EW + 2;           // full limit

endpackage

`default_nettype wire

FILE: sv/obo_sine.sv
// ----------------------------------------------------------------------------
// obo_sine: pipelined Q1.15 sine of a binary angle
// Quadrant fold, Taylor series to the eleventh power, rounding and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module obo_sine import obo_pkg::*; (
  input  wire                          clk,
  input  wire  [SIN_LAT-1:0]           en,
  input  wire  [ANGLE_BITS-1:0]        angle,
  output logic signed [15:0]           value_r
);

  localparam logic [QB:0] QUARTER = {1'b1, {QB{1'b0}}};

  logic [1:0]          quad;
  logic [QB:0]         k_nxt;
  logic [QB:0]         k_r;
  logic [SIN_LAT-2:0]  neg_r;
  logic [X_W-1:0]      x_r;
  logic [X2_W-1:0]     x2_r  [2:10];
  logic [TW-1:0]       term_r[2:12];
  logic signed [SUM_W-1:0] sum_r[2:12];
  logic [TW+14:0]      scaled_r;
  logic [QB+X_W:0]     x_prod;
  logic [2*X_W-1:0]    xx_prod;
  logic [TW+14:0]      sc_nxt;
  logic [TW+14:0]      rnd;
  logic [14:0]         mag;

  assign quad = angle[ANGLE_BITS-1 -: 2];

  always_comb begin
    if (quad[0]) begin
      k_nxt = QUARTER - {1'b0, angle[QB-1:0]};
    end else begin
      k_nxt = {1'b0, angle[QB-1:0]};
    end
  end

  assign x_prod  = k_r * HALF_PI_Q30;
  assign xx_prod = x_r * x_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k_r      <= k_nxt;
      neg_r[0] <= quad[1];
    end
    for (int j = 1; j < SIN_LAT - 1; j++) begin
      if (en[j]) begin
        neg_r[j] <= neg_r[j-1];
      end
    end
    if (en[1]) begin
      x_r <= X_W'(x_prod >> QB);
    end
    if (en[2]) begin
      x2_r[2]   <= X2_W'(xx_prod >> 30);
      term_r[2] <= TW'(x_r);
      sum_r[2]  <= $signed({{(SUM_W-X_W){1'b0}}, x_r});
    end
    for (int j = 3; j <= 10; j++) begin
      if (en[j]) begin
        x2_r[j] <= x2_r[j-1];
      end
    end
  end

  // one series term every two stages: multiply by x^2, then divide by (2n)(2n+1)
  for (genvar n = 1; n <= 5; n++) begin : g_term
    localparam int              DIV = (2 * n) * (2 * n + 1);
    localparam int              SH  = TW + $clog2(DIV);
    localparam logic [63:0]     M64 = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [TW:0]     MUL = M64[TW:0];
    localparam int              SA  = 2 * n + 1;
    localparam int              SB  = 2 * n + 2;

    logic [TW+X2_W-1:0] pa;
    logic [2*TW:0]      pb;
    logic [TW-1:0]      q;

    assign pa = term_r[SA-1] * x2_r[SA-1];
    assign pb = term_r[SA] * MUL;
    assign q  = TW'(pb >> SH);

    always_ff @(posedge clk) begin
      if (en[SA]) begin
        term_r[SA] <= TW'(pa >> 30);
        sum_r[SA]  <= sum_r[SA-1];
      end
      if (en[SB]) begin
        term_r[SB] <= q;
        if (n % 2 == 1) begin
          sum_r[SB] <= sum_r[SB-1] - $signed({1'b0, q});
        end else begin
          sum_r[SB] <= sum_r[SB-1] + $signed({1'b0, q});
        end
      end
    end
  end

  always_comb begin
    if (sum_r[12] < 0) begin
      sc_nxt = '0;
    end else begin
      sc_nxt = TW'(sum_r[12]) * Q15_ONE;
    end
    rnd = scaled_r + (TW+15)'(1 << 29);
    if ((rnd >> 30) > (TW+15)'(Q15_ONE)) begin
      mag = Q15_ONE;
    end else begin
      mag = 15'(rnd >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en[13]) begin
      scaled_r <= sc_nxt;
    end
    if (en[14]) begin
      value_r <= neg_r[13] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

FILE: sv/obo_sep.sv
// ----------------------------------------------------------------------------
// obo_sep: projection and separating axis compare
// Rotates the centre offset into both frames and compares with the extents.
// ----------------------------------------------------------------------------
`default_nettype none

module obo_sep import obo_pkg::*; (
  input  wire                  clk,
  input  wire  [3:0]           en,
  input  wire  signed [DW-1:0] dx,
  input  wire  signed [DW-1:0] dy,
  input  wire  [XW-1:0]        aw,
  input  wire  [XW-1:0]        ah,
  input  wire  [XW-1:0]        bw,
  input  wire  [XW-1:0]        bh,
  input  wire  signed [15:0]   sa,
  input  wire  signed [15:0]   ca,
  input  wire  signed [15:0]   sb,
  input  wire  signed [15:0]   cb,
  input  wire  signed [15:0]   sr,
  input  wire  signed [15:0]   cr,
  output logic                 overlap_r
);

  logic [14:0] msr, mcr;
  assign msr = 15'(sr[15] ? -sr : sr);
  assign mcr = 15'(cr[15] ? -cr : cr);

  // stage 1: products
  logic signed [PW-1:0] axc_r, ays_r, axs_r, ayc_r, bxc_r, bys_r, bxs_r, byc_r;
  logic [EW-1:0] bwc_r, bhs_r, bws_r, bhc_r, awc_r, ahs_r, aws_r, ahc_r;
  logic [EW-1:0] awk_r, ahk_r, bwk_r, bhk_r;

  // stage 2: sums
  logic signed [SW-1:0] atx_r, aty_r, btx_r, bty_r;
  logic [RW-1:0] arx_r, ary_r, brx_r, bry_r;
  logic [EW-1:0] awk2_r, ahk2_r, bwk2_r, bhk2_r;

  // stage 3: magnitudes and limits
  logic [SW-1:0] aax_r, aay_r, abx_r, aby_r;
  logic [LW-1:0] lax_r, lay_r, lbx_r, lby_r;

  logic sep;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      axc_r <= dx * ca;
      ays_r <= dy * sa;
      axs_r <= dx * sa;
      ayc_r <= dy * ca;
      bxc_r <= dx * cb;
      bys_r <= dy * sb;
      bxs_r <= dx * sb;
      byc_r <= dy * cb;
      bwc_r <= bw * mcr;
      bhs_r <= bh * msr;
      bws_r <= bw * msr;
      bhc_r <= bh * mcr;
      awc_r <= aw * mcr;
      ahs_r <= ah * msr;
      aws_r <= aw * msr;
      ahc_r <= ah * mcr;
      awk_r <= aw * Q15_ONE;
      ahk_r <= ah * Q15_ONE;
      bwk_r <= bw * Q15_ONE;
      bhk_r <= bh * Q15_ONE;
    end
    if (en[1]) begin
      atx_r  <= SW'(axc_r) + SW'(ays_r);
      aty_r  <= SW'(ayc_r) - SW'(axs_r);
      // b frame uses the negated offset, which only flips the sign
      btx_r  <= SW'(bxc_r) + SW'(bys_r);
      bty_r  <= SW'(byc_r) - SW'(bxs_r);
      arx_r  <= RW'(bwc_r) + RW'(bhs_r);
      ary_r  <= RW'(bws_r) + RW'(bhc_r);
      brx_r  <= RW'(awc_r) + RW'(ahs_r);
      bry_r  <= RW'(aws_r) + RW'(ahc_r);
      awk2_r <= awk_r;
      ahk2_r <= ahk_r;
      bwk2_r <= bwk_r;
      bhk2_r <= bhk_r;
    end
    if (en[2]) begin
      aax_r <= SW'(atx_r[SW-1] ? -atx_r : atx_r);
      aay_r <= SW'(aty_r[SW-1] ? -aty_r : aty_r);
      abx_r <= SW'(btx_r[SW-1] ? -btx_r : btx_r);
      aby_r <= SW'(bty_r[SW-1] ? -bty_r : bty_r);
      lax_r <= LW'(awk2_r) + LW'(arx_r);
      lay_r <= LW'(ahk2_r) + LW'(ary_r);
      lbx_r <= LW'(bwk2_r) + LW'(brx_r);
      lby_r <= LW'(bhk2_r) + LW'(bry_r);
    end
    if (en[3]) begin
      overlap_r <= !sep;
    end
  end

  // touching counts as overlap
  assign sep = (aax_r > SW'(lax_r)) || (aay_r > SW'(lay_r)) ||
               (abx_r > SW'(lbx_r)) || (aby_r > SW'(lby_r));

endmodule

`default_nettype wire

FILE: sv/oriented_box_overlap_test.sv
// ----------------------------------------------------------------------------
// oriented_box_overlap_test: 2-D separating axis test for two oriented boxes
//
//   channel   ports      beat contents
//   input     in_*       box A and box B: centres, half extents, angles
//   result    out_*      overlap flag, one beat per input beat
//
// One beat is accepted per cycle while the result side does not stall; each
// result passes through the input register, the 15-stage sine unit and the
// four projection and compare stages.
// Every stage holds its beat until the next stage has room, so bubbles
// close up and a stalled result does not block input until the pipe is full.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_box_overlap_test import obo_pkg::*; (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // a_center_x, a_center_y, a_half_width, a_half_height, a_angle,
  // b_center_x, b_center_y, b_half_width, b_half_height, b_angle
  input  wire  [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  // overlap
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [ANGLE_BITS-1:0] QTR = {2'b01, {QB{1'b0}}};

  logic [NST-1:0] v_r;
  logic [NST-1:0] stage_en;

  // stage i moves when it is empty or its successor moves
  always_comb begin
    stage_en[NST-1] = !v_r[NST-1] || out_tready;
    for (int j = NST - 2; j >= 0; j--) begin
      stage_en[j] = !v_r[j] || stage_en[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stage_en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int j = 1; j < NST; j++) begin
        if (stage_en[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
    end
  end

  // input fields
  logic signed [CW-1:0]  acx, acy, bcx, bcy;
  logic [ANGLE_BITS-1:0] aang, bang;

  assign acx  = in_tdata[OFS_ACX +: CW];
  assign acy  = in_tdata[OFS_ACY +: CW];
  assign bcx  = in_tdata[OFS_BCX +: CW];
  assign bcy  = in_tdata[OFS_BCY +: CW];
  assign aang = in_tdata[OFS_AAN + AW - 1 -: ANGLE_BITS];
  assign bang = in_tdata[OFS_BAN + AW - 1 -: ANGLE_BITS];

  logic signed [DW-1:0]  dx_r[0:SIN_LAT];
  logic signed [DW-1:0]  dy_r[0:SIN_LAT];
  logic [XW-1:0]         aw_r[0:SIN_LAT];
  logic [XW-1:0]         ah_r[0:SIN_LAT];
  logic [XW-1:0]         bw_r[0:SIN_LAT];
  logic [XW-1:0]         bh_r[0:SIN_LAT];
  logic [ANGLE_BITS-1:0] aang_r, bang_r, rel_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dx_r[0] <= DW'(bcx) - DW'(acx);
      dy_r[0] <= DW'(bcy) - DW'(acy);
      aw_r[0] <= in_tdata[OFS_AHW +: XW];
      ah_r[0] <= in_tdata[OFS_AHH +: XW];
      bw_r[0] <= in_tdata[OFS_BHW +: XW];
      bh_r[0] <= in_tdata[OFS_BHH +: XW];
      aang_r  <= aang;
      bang_r  <= bang;
      rel_r   <= bang - aang;
    end
    // offsets and extents wait alongside the sine units
    for (int j = 1; j <= SIN_LAT; j++) begin
      if (stage_en[j]) begin
        dx_r[j] <= dx_r[j-1];
        dy_r[j] <= dy_r[j-1];
        aw_r[j] <= aw_r[j-1];
        ah_r[j] <= ah_r[j-1];
        bw_r[j] <= bw_r[j-1];
        bh_r[j] <= bh_r[j-1];
      end
    end
  end

  logic signed [15:0] sa, ca, sb, cb, sr, cr;

  obo_sine u_sin_a (.clk(clk), .en(stage_en[SIN_LAT:1]), .angle(aang_r), .value_r(sa));
  obo_sine u_cos_a (.clk(clk), .en(stage_en[SIN_LAT:1]), .angle(aang_r + QTR),
                    .value_r(ca));
  obo_sine u_sin_b (.clk(clk), .en(stage_en[SIN_LAT:1]), .angle(bang_r), .value_r(sb));
  obo_sine u_cos_b (.clk(clk), .en(stage_en[SIN_LAT:1]), .angle(bang_r + QTR),
                    .value_r(cb));
  obo_sine u_sin_r (.clk(clk), .en(stage_en[SIN_LAT:1]), .angle(rel_r), .value_r(sr));
  obo_sine u_cos_r (.clk(clk), .en(stage_en[SIN_LAT:1]), .angle(rel_r + QTR),
                    .value_r(cr));

  logic overlap;

  obo_sep u_sep (
    .clk      (clk),
    .en       (stage_en[NST-1:SIN_LAT+1]),
    .dx       (dx_r[SIN_LAT]),
    .dy       (dy_r[SIN_LAT]),
    .aw       (aw_r[SIN_LAT]),
    .ah       (ah_r[SIN_LAT]),
    .bw       (bw_r[SIN_LAT]),
    .bh       (bh_r[SIN_LAT]),
    .sa       (sa),
    .ca       (ca),
    .sb       (sb),
    .cb       (cb),
    .sr       (sr),
    .cr       (cr),
    .overlap_r(overlap)
  );

  assign in_tready  = stage_en[0];
  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, overlap};

endmodule

`default_nettype wire

FILE: sv/obo_chk.sv
// ----------------------------------------------------------------------------
// obo_chk: port checks for the oriented box overlap test
// Watches the top level handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module obo_chk import obo_pkg::*; (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_tvalid,
  input wire                  in_tready,
  input wire                  out_tvalid,
  input wire                  out_tready,
  input wire [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // input only backs up behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("pipe not empty after reset");

  // only the flag bit of the result carries data
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:1] == '0)
    else $error("result padding not zero");

endmodule

bind oriented_box_overlap_test obo_chk u_obo_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
